// ----- hdl/spm_pkg.sv -----
// Shared types and constants for the sparse polynomial multiplier.
package spm_pkg;

   localparam int COEF_W    = 16;
   localparam int EXP_W     = 5;
   localparam int RES_EXP_W = 6;
   localparam int ACC_W     = 48;
   localparam int PROD_W    = 2 * COEF_W;

   localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
   localparam logic [1:0] MODE_MULTIPLY    = 2'd2;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [COEF_W-1:0] term_coefficient;
      logic [EXP_W-1:0]         term_exponent;
   } req_type;

   typedef struct packed {
      logic [RES_EXP_W-1:0]    result_exponent;
      logic signed [ACC_W-1:0] result_coefficient;
      logic                    last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PAIR_RD,
      ST_PAIR_MUL,
      ST_PAIR_ACC,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

// ----- hdl/sparse_polynomial_multiplier.sv -----
// Sparse polynomial multiplier: term tables, product store and sequencer.
//
// Usage: a request transfers when start is high and busy is low. Mode 0 and
// mode 1 store one term (coefficient, exponent) of the first or second
// polynomial, and busy stays low. Terms beyond MAX_TERMS are dropped,
// exponents above MAX_TERM_EXPONENT saturate. Mode 3 is ignored. Mode 2
// multiplies: busy rises and the sequencer first clears the product store,
// then runs every term pair through one shared 16x16 multiplier and a
// read-add-write of the store. It then reads the store from the highest
// product exponent down to zero; busy stays high until the last result.
// Each result is on rsp for one cycle with rsp_strobe high; the receiver
// cannot stall, so nothing is held back. The exponent-zero result carries
// last, and both term counts are then zero again.
// Reset clears the counts and the sequencer; table contents stay undefined.
module sparse_polynomial_multiplier
   import spm_pkg::*;
#(
   parameter int MAX_TERMS         = 16,
   parameter int MAX_TERM_EXPONENT = 31
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   localparam int STORE_DEPTH = 2 * MAX_TERM_EXPONENT + 1;
   localparam int SA_W        = $clog2(STORE_DEPTH);
   localparam int IDX_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W       = $clog2(MAX_TERMS + 1);

   // term tables and product store
   logic signed [COEF_W-1:0] first_coef_mem  [MAX_TERMS];
   logic [EXP_W-1:0]         first_exp_mem   [MAX_TERMS];
   logic signed [COEF_W-1:0] second_coef_mem [MAX_TERMS];
   logic [EXP_W-1:0]         second_exp_mem  [MAX_TERMS];
   logic [ACC_W-1:0]         store_mem       [STORE_DEPTH];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [SA_W-1:0]  idx_ff, idx_in;
   logic [SA_W-1:0]  hi_ff, hi_in;
   logic [SA_W-1:0]  sum_ff, sum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_strobe_ff, rsp_strobe_in;

   logic signed [COEF_W-1:0] first_c_ff, second_c_ff;
   logic [EXP_W-1:0]         first_e_ff, second_e_ff;
   logic [ACC_W-1:0]         store_rd_ff;

   logic                 load_first, load_second;
   logic [EXP_W-1:0]     sat_exp;
   logic [RES_EXP_W-1:0] raw_sum;
   logic [SA_W-1:0]      sat_sum;
   logic [SA_W-1:0]      store_raddr;
   logic                 store_we;
   logic [SA_W-1:0]      store_waddr;
   logic [ACC_W-1:0]     store_wdata;
   logic                 i_last, j_last;
   logic [SA_W-1:0]      hi_next;

   assign busy = (state_ff != ST_IDLE);

   assign load_first  = start && !busy && (req.mode == MODE_LOAD_FIRST)
                        && (first_count_ff < CNT_W'(MAX_TERMS));
   assign load_second = start && !busy && (req.mode == MODE_LOAD_SECOND)
                        && (second_count_ff < CNT_W'(MAX_TERMS));
   assign sat_exp = (req.term_exponent > EXP_W'(MAX_TERM_EXPONENT))
                    ? EXP_W'(MAX_TERM_EXPONENT) : req.term_exponent;

   always_ff @(posedge clock) begin
      if (load_first) begin
         first_coef_mem[first_count_ff[IDX_W-1:0]] <= req.term_coefficient;
         first_exp_mem[first_count_ff[IDX_W-1:0]]  <= sat_exp;
      end
      if (load_second) begin
         second_coef_mem[second_count_ff[IDX_W-1:0]] <= req.term_coefficient;
         second_exp_mem[second_count_ff[IDX_W-1:0]]  <= sat_exp;
      end
      first_c_ff  <= first_coef_mem[i_ff];
      first_e_ff  <= first_exp_mem[i_ff];
      second_c_ff <= second_coef_mem[j_ff];
      second_e_ff <= second_exp_mem[j_ff];
   end

   // exponent sum, clamped to the top store entry
   assign raw_sum = {1'b0, first_e_ff} + {1'b0, second_e_ff};
   assign sat_sum = (raw_sum > RES_EXP_W'(STORE_DEPTH - 1))
                    ? SA_W'(STORE_DEPTH - 1) : raw_sum[SA_W-1:0];

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   assign i_last  = (CNT_W'(i_ff) + CNT_W'(1)) == first_count_ff;
   assign j_last  = (CNT_W'(j_ff) + CNT_W'(1)) == second_count_ff;
   assign hi_next = (sum_ff > hi_ff) ? sum_ff : hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      idx_ff  <= idx_in;
      hi_ff   <= hi_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      idx_in          = idx_ff;
      hi_in           = hi_ff;
      sum_in          = sum_ff;
      prod_in         = prod_ff;
      rsp_in          = rsp_ff;
      rsp_strobe_in   = 1'b0;
      store_raddr     = idx_ff;
      store_we        = 1'b0;
      store_waddr     = idx_ff;
      store_wdata     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (load_first) begin
               first_count_in = first_count_ff + CNT_W'(1);
            end
            if (load_second) begin
               second_count_in = second_count_ff + CNT_W'(1);
            end
            if (start && (req.mode == MODE_MULTIPLY)) begin
               idx_in   = '0;
               hi_in    = '0;
               i_in     = '0;
               j_in     = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            store_we = 1'b1;
            if (idx_ff == SA_W'(STORE_DEPTH - 1)) begin
               idx_in = '0;
               if (first_count_ff == '0 || second_count_ff == '0) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_PAIR_RD;
               end
            end else begin
               idx_in = idx_ff + SA_W'(1);
            end
         end
         ST_PAIR_RD: begin
            state_in = ST_PAIR_MUL;
         end
         ST_PAIR_MUL: begin
            prod_in     = first_c_ff * second_c_ff;
            sum_in      = sat_sum;
            store_raddr = sat_sum;
            state_in    = ST_PAIR_ACC;
         end
         ST_PAIR_ACC: begin
            store_we    = 1'b1;
            store_waddr = sum_ff;
            store_wdata = store_rd_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            hi_in       = hi_next;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  idx_in   = hi_next;
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_PAIR_RD;
               end
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_PAIR_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_strobe_in             = 1'b1;
            rsp_in.result_exponent    = RES_EXP_W'(idx_ff);
            rsp_in.result_coefficient = store_rd_ff;
            rsp_in.last               = (idx_ff == '0);
            if (idx_ff == '0) begin
               first_count_in  = '0;
               second_count_in = '0;
               state_in        = ST_IDLE;
            end else begin
               idx_in   = idx_ff - SA_W'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ----- hdl/spm_checker.sv -----
// Port-level checks for the sparse polynomial multiplier, bound to the top.
module spm_checker
   import spm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req,
   input logic    rsp_strobe,
   input rsp_type rsp
);

   // result strobes are never back to back
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // exponents descend by one until last
   a_descending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.last |-> ##2 (rsp_strobe
         && rsp.result_exponent == $past(rsp.result_exponent, 2) - 6'd1))
      else $error("result exponent sequence broken");

   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.last |-> rsp.result_exponent == '0)
      else $error("last set on nonzero exponent");

   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.last |-> busy)
      else $error("not busy in the middle of a result burst");

   a_multiply_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req.mode == MODE_MULTIPLY |=> busy)
      else $error("multiply transfer did not raise busy");

endmodule

bind sparse_polynomial_multiplier spm_checker u_spm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req        (req),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

// ----- tb/sparse_polynomial_multiplier_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sparse polynomial multiplier.
module sparse_polynomial_multiplier_test;
   import spm_pkg::*;

   localparam int TERM_DEPTH   = 16;
   localparam int MAX_EXP      = 31;
   localparam int STORE_DEPTH  = 2 * MAX_EXP + 1;
   localparam int DRAIN_CYCLES = 100;
   localparam int REPORT_LIMIT = 10;
   localparam int REQ_W        = $bits(req_type);
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_strobe;
   rsp_type rsp;

   // predictor state
   logic signed [COEF_W-1:0] first_coef  [TERM_DEPTH];
   logic [EXP_W-1:0]         first_exp   [TERM_DEPTH];
   logic signed [COEF_W-1:0] second_coef [TERM_DEPTH];
   logic [EXP_W-1:0]         second_exp  [TERM_DEPTH];
   int first_count  = 0;
   int second_count = 0;
   rsp_type expected_coefficients[$];

   int error_count     = 0;
   int sender_idle_pct = 0;
   int items_sent      = 0;

   sparse_polynomial_multiplier uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("** sparse_polynomial_multiplier: FAILED **");
      $finish;
   end

   // Updates the term tables, or forms the product and queues its coefficients.
   task automatic predict_product(input req_type item);
      logic signed [ACC_W-1:0] store [STORE_DEPTH];
      logic signed [ACC_W-1:0] product;
      int sum;
      int top;
      rsp_type r;
      case (item.mode)
         MODE_LOAD_FIRST: if (first_count < TERM_DEPTH) begin
            first_coef[first_count] = item.term_coefficient;
            first_exp[first_count]  = EXP_W'((item.term_exponent > MAX_EXP)
                                             ? MAX_EXP : item.term_exponent);
            first_count++;
         end
         MODE_LOAD_SECOND: if (second_count < TERM_DEPTH) begin
            second_coef[second_count] = item.term_coefficient;
            second_exp[second_count]  = EXP_W'((item.term_exponent > MAX_EXP)
                                               ? MAX_EXP : item.term_exponent);
            second_count++;
         end
         MODE_MULTIPLY: begin
            for (int k = 0; k < STORE_DEPTH; k++) store[k] = '0;
            top = 0;
            for (int i = 0; i < first_count; i++) begin
               for (int j = 0; j < second_count; j++) begin
                  sum = int'(first_exp[i]) + int'(second_exp[j]);
                  if (sum >= STORE_DEPTH) sum = STORE_DEPTH - 1;
                  product = first_coef[i] * second_coef[j];
                  store[sum] = store[sum] + product;
                  if (sum > top) top = sum;
               end
            end
            for (int x = top; x >= 0; x--) begin
               r.result_exponent    = RES_EXP_W'(x);
               r.result_coefficient = store[x];
               r.last               = (x == 0);
               expected_coefficients.push_back(r);
            end
            first_count  = 0;
            second_count = 0;
         end
         default: ;
      endcase
   endtask

   task automatic check_coefficient(input rsp_type got);
      rsp_type want;
      if (expected_coefficients.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: unexpected result exp=%0d coef=%0d last=%0b",
                     $realtime, got.result_exponent, got.result_coefficient, got.last);
      end else begin
         want = expected_coefficients.pop_front();
         if (got.result_exponent !== want.result_exponent ||
             got.result_coefficient !== want.result_coefficient ||
             got.last !== want.last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: mismatch exp=%0d/%0d coef=%0d/%0d last=%0b/%0b (got/expected)",
                        $realtime, got.result_exponent, want.result_exponent,
                        got.result_coefficient, want.result_coefficient,
                        got.last, want.last);
         end
      end
   endtask

   // Pre-edge values are sampled here, so DUT updates at this edge are not seen.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) check_coefficient(rsp);
         if (start && !busy) predict_product(req);
      end
   end

   // Called right after a falling edge; returns after the transfer.
   task automatic send_item(input req_type item);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) begin
            req = REQ_W'($urandom);
            @(negedge clock);
         end
      end
      start = 1'b1;
      req   = item;
      while (busy) @(negedge clock);
      @(negedge clock);
      if (item.mode != MODE_UNUSED) items_sent++;
   endtask

   task automatic send_term(input logic [1:0] mode, input int coef, input int exponent);
      req_type item;
      item.mode             = mode;
      item.term_coefficient = COEF_W'(coef);
      item.term_exponent    = EXP_W'(exponent);
      send_item(item);
   endtask

   task automatic wait_for_results();
      start = 1'b0;
      while (expected_coefficients.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // First table overfilled; the seventeenth term must be dropped.
   task automatic test_full_table();
      for (int i = 0; i < TERM_DEPTH; i++)
         send_term(MODE_LOAD_FIRST, (i % 2) ? 32767 : -32768, (i % 2) ? 0 : MAX_EXP);
      send_term(MODE_LOAD_FIRST, 1, 5);
      send_term(MODE_LOAD_SECOND, -32768, MAX_EXP);
      send_term(MODE_MULTIPLY, $urandom, $urandom);
   endtask

   task automatic test_empty_polynomial();
      send_term(MODE_MULTIPLY, 0, 0);
      send_term(MODE_LOAD_SECOND, 32767, 7);
      send_term(MODE_MULTIPLY, -1, MAX_EXP);
   endtask

   task automatic test_unused_mode();
      send_term(MODE_UNUSED, -32768, MAX_EXP);
      send_term(MODE_LOAD_FIRST, -1, 3);
      send_term(MODE_UNUSED, 32767, 0);
      send_term(MODE_LOAD_SECOND, 2, 4);
      send_term(MODE_MULTIPLY, 0, 0);
   endtask

   task automatic send_random_term(input logic [1:0] mode);
      int coef;
      int exponent;
      case ($urandom_range(7))
         0: coef = -32768;
         1: coef = 32767;
         default: coef = $urandom_range(0, 65535) - 32768;
      endcase
      exponent = ($urandom_range(7) == 0) ? (($urandom_range(1)) ? MAX_EXP : 0)
                                          : $urandom_range(0, MAX_EXP);
      send_term(mode, coef, exponent);
   endtask

   // Mostly small polynomials, a few near or past the table depth, some noise.
   task automatic send_random_product();
      int n1;
      int n2;
      int a;
      int b;
      n1 = ($urandom_range(99) < 8) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      n2 = ($urandom_range(99) < 8) ? $urandom_range(14, 18) : $urandom_range(0, 5);
      a = 0;
      b = 0;
      while (a < n1 || b < n2) begin
         if ($urandom_range(99) < 5)
            send_random_term(MODE_UNUSED);
         else if (b >= n2 || (a < n1 && $urandom_range(1))) begin
            send_random_term(MODE_LOAD_FIRST);
            a++;
         end else begin
            send_random_term(MODE_LOAD_SECOND);
            b++;
         end
      end
      if ($urandom_range(99) < 90) send_random_term(MODE_MULTIPLY);
   endtask

   task automatic run_random_phase(input int idle_pct, input int count);
      int target;
      bit drained;
      sender_idle_pct = idle_pct;
      target  = items_sent + count;
      drained = 1'b0;
      while (items_sent < target) begin
         send_random_product();
         if (!drained && items_sent > target - count / 2) begin
            wait_for_results();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;

      sender_idle_pct = 29;
      test_full_table();
      test_empty_polynomial();
      test_unused_mode();

      run_random_phase(29, 125);
      run_random_phase(65, 125);
      run_random_phase(0, 125);
      // the last product may be partly loaded; flush it
      send_term(MODE_MULTIPLY, 0, 0);

      wait_for_results();
      if (error_count == 0)
         $display("** sparse_polynomial_multiplier: PASSED **");
      else
         $display("** sparse_polynomial_multiplier: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/spm_pkg.sv
hdl/sparse_polynomial_multiplier.sv
hdl/spm_checker.sv
tb/sparse_polynomial_multiplier_test.sv
